FILE: design/svc_pkg.sv
`timescale 1ns / 1ps
// Package for the stereo volume soft clipper.
// Holds the pipeline control struct and the fixed curve constants; no dependencies.
package svc_pkg;

  // Number of register stages in the sample path, output register included.
  localparam int SVC_STAGES = 4;

  // Volume factor: reset value, unity point and the shift that divides by it.
  localparam logic [7:0] SVC_VOL_RESET  = 8'd128;
  localparam logic [7:0] SVC_VOL_UNITY  = 8'd128;
  localparam int         SVC_UNITY_SHIFT = 7;

  // Soft clip curve: knee, ceiling, and the magnitude where the curve goes flat.
  localparam logic [16:0] SVC_KNEE      = 17'd24576;
  localparam logic [16:0] SVC_CEIL      = 17'd32767;
  localparam logic [16:0] SVC_SAT_LEVEL = 17'd40958;

  // The curve divides the squared excess by 4 * 8191; 8191 is 2^13 - 1.
  localparam int          SVC_DIV_BITS = 13;
  localparam logic [13:0] SVC_DIV_BASE = 14'd8191;

  // Control that the pipeline controller hands to both lanes.
  typedef struct packed {
    logic [SVC_STAGES-1:0] load;
    logic [7:0]            factor;
  } svc_ctl_t;

endpackage

FILE: design/svc_in_if.sv
`timescale 1ns / 1ps
// Input channel: one stereo frame word with valid/ready.
// Standalone interface; no package dependency.
interface svc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               buffer_end;

  modport source (output valid, output left_sample, output right_sample,
                  output buffer_end, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input buffer_end, output ready);
endinterface

FILE: design/svc_out_if.sv
`timescale 1ns / 1ps
// Result channel: one processed stereo frame word with valid/ready.
// Standalone interface; no package dependency.
interface svc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic               buffer_end_out;

  modport source (output valid, output left_out, output right_out,
                  output buffer_end_out, input ready);
  modport sink   (input valid, input left_out, input right_out,
                  input buffer_end_out, output ready);
endinterface

FILE: design/svc_cfg_if.sv
`timescale 1ns / 1ps
// Configuration channel: one volume factor word with valid/ready.
// Standalone interface; no package dependency.
interface svc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] volume_factor;

  modport source (output valid, output volume_factor, input ready);
  modport sink   (input valid, input volume_factor, output ready);
endinterface

FILE: design/svc_lane.sv
`timescale 1ns / 1ps
// One channel of the sample path: scale, magnitude, square, bend, in four stages.
// Depends on svc_pkg for the curve constants and the control struct.
module svc_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  svc_pkg::svc_ctl_t  ctl,
  input  logic signed [15:0] sample,
  output logic signed [15:0] result
);
  import svc_pkg::*;

  // Stage 1: product of sample and volume factor.
  logic signed [24:0] prod1_r, prod1_nxt;
  logic               boost1_r, boost1_nxt;

  // Stage 2: magnitude of the scaled sample and its sign.
  logic signed [24:0] round2;
  logic signed [17:0] scaled2;
  logic        [17:0] abs2;
  logic        [16:0] mag2_r, mag2_nxt;
  logic               neg2_r, neg2_nxt;
  logic               boost2_r;

  // Stage 3: excess over the knee, its square and the curve flags.
  logic [16:0] over_full3;
  logic [13:0] over3_r, over3_nxt;
  logic [27:0] sq3_r, sq3_nxt;
  logic [16:0] mag3_r;
  logic        neg3_r;
  logic        shape3_r, shape3_nxt;
  logic        sat3_r, sat3_nxt;

  // Stage 4: divide the square, bend the magnitude, restore the sign.
  logic [25:0] quarter4;
  logic [12:0] q0_4;
  logic [13:0] rem4;
  logic [12:0] quot4;
  logic [15:0] bent4;
  logic [16:0] mag_fin4;
  logic [16:0] signed_fin4;
  logic [15:0] res4_r, res4_nxt;

  // Stage 1 logic: a 16 by 9 signed multiply.
  always_comb begin
    prod1_nxt  = sample * $signed({1'b0, ctl.factor});
    boost1_nxt = (ctl.factor > SVC_VOL_UNITY);
  end

  // Stage 2 logic: divide by the unity factor, truncating toward zero.
  always_comb begin
    neg2_nxt = prod1_r[24];
    round2   = prod1_r + (prod1_r[24] ? 25'sd127 : 25'sd0);
    scaled2  = round2[24:SVC_UNITY_SHIFT];
    abs2     = neg2_nxt ? 18'(-scaled2) : 18'(scaled2);
    mag2_nxt = abs2[16:0];
  end

  // Stage 3 logic: excess over the knee and its square.
  always_comb begin
    over_full3 = mag2_r - SVC_KNEE;
    over3_nxt  = over_full3[13:0];
    sq3_nxt    = 28'(over3_nxt) * 28'(over3_nxt);
    shape3_nxt = boost2_r && (mag2_r > SVC_KNEE);
    sat3_nxt   = (mag2_r >= SVC_SAT_LEVEL);
  end

  // Stage 4 logic: floor(sq / 32764) as floor(floor(sq / 4) / 8191).
  // With 8191 = 2^13 - 1 the remainder of the shift estimate stays below
  // twice the divisor, so one compare finishes the quotient.
  always_comb begin
    quarter4 = sq3_r[27:2];
    q0_4     = quarter4[25:SVC_DIV_BITS];
    rem4     = {1'b0, quarter4[SVC_DIV_BITS-1:0]} + {1'b0, q0_4};
    quot4    = q0_4 + ((rem4 >= SVC_DIV_BASE) ? 13'd1 : 13'd0);
    bent4    = SVC_KNEE[15:0] + {2'b00, over3_r} - {3'b000, quot4};
    if (shape3_r) begin
      mag_fin4 = sat3_r ? SVC_CEIL : {1'b0, bent4};
    end else begin
      mag_fin4 = mag3_r;
    end
    signed_fin4 = neg3_r ? (~mag_fin4 + 17'd1) : mag_fin4;
    res4_nxt    = signed_fin4[15:0];
  end

  // Stage registers; each loads when its control bit says a word moves in.
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      prod1_r  <= prod1_nxt;
      boost1_r <= boost1_nxt;
    end
    if (ctl.load[1]) begin
      mag2_r   <= mag2_nxt;
      neg2_r   <= neg2_nxt;
      boost2_r <= boost1_r;
    end
    if (ctl.load[2]) begin
      over3_r  <= over3_nxt;
      sq3_r    <= sq3_nxt;
      mag3_r   <= mag2_r;
      neg3_r   <= neg2_r;
      shape3_r <= shape3_nxt;
      sat3_r   <= sat3_nxt;
    end
    if (ctl.load[3]) begin
      res4_r <= res4_nxt;
    end
  end

  assign result = $signed(res4_r);

  // The single correction step must leave a remainder below twice the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (shape3_r && !sat3_r) |-> (rem4 < {SVC_DIV_BASE[12:0], 1'b0}))
    else $error("svc_lane: divide remainder out of range");

  // A bent magnitude never passes the ceiling.
  a_bent_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    (shape3_r && !sat3_r) |-> ({1'b0, bent4} <= SVC_CEIL))
    else $error("svc_lane: bent magnitude above ceiling");

endmodule

FILE: design/svc_ctrl.sv
`timescale 1ns / 1ps
// Pipeline control: volume register, per-stage valid bits, ready chain, end-mark path.
// Depends on svc_pkg for the stage count and the control struct.
module svc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_buffer_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_buffer_end,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  output svc_pkg::svc_ctl_t ctl
);
  import svc_pkg::*;

  logic [7:0]            volume_r, volume_nxt;
  logic [SVC_STAGES-1:0] valid_r, valid_nxt;
  logic [SVC_STAGES-1:0] end_r;
  logic [SVC_STAGES-1:0] rdy;
  logic [SVC_STAGES-1:0] feed;
  logic [SVC_STAGES-1:0] load;

  // Takes every volume write; writes must come only while idle, not enforced here.
  assign cfg_ready  = 1'b1;
  assign volume_nxt = (cfg_valid) ? cfg_data : volume_r;

  // A stage can take a word when it is empty or its word moves on this cycle.
  always_comb begin
    rdy[SVC_STAGES-1] = !valid_r[SVC_STAGES-1] || out_ready;
    for (int k = SVC_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  // What each stage would receive, and whether a real word moves into it.
  always_comb begin
    feed[0] = in_valid;
    for (int k = 1; k < SVC_STAGES; k++) begin
      feed[k] = valid_r[k-1];
    end
    load = rdy & feed;
    for (int k = 0; k < SVC_STAGES; k++) begin
      valid_nxt[k] = rdy[k] ? feed[k] : valid_r[k];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= SVC_VOL_RESET;
      valid_r  <= '0;
    end else begin
      volume_r <= volume_nxt;
      valid_r  <= valid_nxt;
    end
  end

  // The end-of-buffer mark rides alongside the samples.
  always_ff @(posedge clk) begin
    if (load[0]) begin
      end_r[0] <= in_buffer_end;
    end
    for (int k = 1; k < SVC_STAGES; k++) begin
      if (load[k]) begin
        end_r[k] <= end_r[k-1];
      end
    end
  end

  assign in_ready       = rdy[0];
  assign out_valid      = valid_r[SVC_STAGES-1];
  assign out_buffer_end = end_r[SVC_STAGES-1];
  assign ctl.load       = load;
  assign ctl.factor     = volume_r;

  // A held result must not be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !load[SVC_STAGES-1])
    else $error("svc_ctrl: output register loaded while stalled");

  // A blocked word in the middle of the pipe is still there next cycle.
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[1] && !rdy[2]) |=> valid_r[1])
    else $error("svc_ctrl: stalled word lost in stage two");

  // An empty first stage always accepts.
  a_bubble_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[0] |-> in_ready)
    else $error("svc_ctrl: empty first stage not ready");

endmodule

FILE: design/stereo_volume_soft_clipper.sv
`timescale 1ns / 1ps
// Stereo volume with quadratic soft clip: top level, two lanes and a controller.
// A frame accepted into the stage 1 register moves through stages 2 and 3 into the output register.
// Throughput: one frame per cycle while the output is not stalled; each stage holds one word and the ready chain
// lets empty stages fill while the output is stalled.
// Reset (rst_n, synchronous, active low) empties the pipe and sets volume to 128.
// Depends on svc_pkg, svc_in_if, svc_out_if, svc_cfg_if, svc_lane and svc_ctrl.
module stereo_volume_soft_clipper (
  input  logic      clk,
  input  logic      rst_n,
  svc_in_if.sink    in_if,
  svc_out_if.source out_if,
  svc_cfg_if.sink   cfg_if
);
  import svc_pkg::*;

  svc_ctl_t ctl;

  // Handshakes, volume register and valid bits.
  svc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_if.valid),
    .in_ready       (in_if.ready),
    .in_buffer_end  (in_if.buffer_end),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_buffer_end (out_if.buffer_end_out),
    .cfg_valid      (cfg_if.valid),
    .cfg_ready      (cfg_if.ready),
    .cfg_data       (cfg_if.volume_factor),
    .ctl            (ctl)
  );

  // Left channel sample path.
  svc_lane u_lane_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_if.left_sample),
    .result (out_if.left_out)
  );

  // Right channel sample path.
  svc_lane u_lane_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_if.right_sample),
    .result (out_if.right_out)
  );

endmodule
